// ===== src/rmq_pkg.sv =====
// Package with the shared types, constants and helper function of the matrix-to-quaternion block.
`default_nettype none
package rmq_pkg;

    localparam int ONE_Q14 = 16384;
    localparam int RAD_W = 34;    // radicand A*16384 fits in 33 bits, one spare
    localparam int ROOT_W = 17;   // floor(sqrt) of the radicand
    localparam int NUM_W = 18;    // signed sum or difference of two inputs
    localparam int MAG_W = 17;    // magnitude of a numerator
    localparam int DEN_W = 18;    // S = 2*Q
    localparam int QUO_W = 17;    // quotient bits kept before the clamp
    localparam int DIVIDEND_W = MAG_W + 14 + 1;
    localparam int SQRT_STEPS = RAD_W / 2;

    typedef enum logic [1:0] {
        BR_W = 2'd0,
        BR_X = 2'd1,
        BR_Y = 2'd2,
        BR_Z = 2'd3
    } branch_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } mat_t;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } quat_t;

    // Data carried along the square-root chain.
    typedef struct packed {
        logic                    valid;
        branch_t                 branch;
        logic [RAD_W-1:0]        rem;
        logic [ROOT_W-1:0]       root;
        logic signed [NUM_W-1:0] num_a;
        logic signed [NUM_W-1:0] num_b;
        logic signed [NUM_W-1:0] num_c;
    } sqrt_tok_t;

    // Data carried along the division chain; three lanes run in parallel.
    typedef struct packed {
        logic                    valid;
        branch_t                 branch;
        logic [DEN_W-1:0]        den;
        logic [2:0]              neg;
        logic [2:0]              nz;
        logic [3*DIVIDEND_W-1:0] rem;
        logic [3*QUO_W-1:0]      quo;
    } div_tok_t;

    // Saturate a signed 20-bit value to 16 bits.
    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -20'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/rmq_sqrt_cell.sv =====
// One cell of the square-root chain: produces one result bit of floor(sqrt(radicand)).
`default_nettype none
module rmq_sqrt_cell
    import rmq_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        adv,
    input  sqrt_tok_t  tok_in,
    output sqrt_tok_t  tok_out
);

    localparam int SH = 2 * (SQRT_STEPS - 1 - STEP);

    sqrt_tok_t tok_reg, tok_next;
    logic [RAD_W-1:0] trial;

    // Restoring square-root step: try (4*root+1) << SH against the remainder.
    always_comb begin
        tok_next = tok_in;
        trial = ({{(RAD_W-ROOT_W){1'b0}}, tok_in.root} << (SH + 2))
              | ({{(RAD_W-1){1'b0}}, 1'b1} << SH);
        tok_next.root = {tok_in.root[ROOT_W-2:0], 1'b0};
        if (tok_in.rem >= trial) begin
            tok_next.rem = tok_in.rem - trial;
            tok_next.root = {tok_in.root[ROOT_W-2:0], 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else if (adv) begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule
`default_nettype wire

// ===== src/rmq_div_cell.sv =====
// One cell of the division chain: produces one quotient bit for each of three lanes.
`default_nettype none
module rmq_div_cell
    import rmq_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire       aclk,
    input  wire       aresetn,
    input  wire       adv,
    input  div_tok_t  tok_in,
    output div_tok_t  tok_out
);

    localparam int SH = QUO_W - 1 - STEP;

    div_tok_t tok_reg, tok_next;
    logic [DIVIDEND_W+QUO_W-1:0] dshift;

    // Restoring division step on each lane.
    always_comb begin
        tok_next = tok_in;
        dshift = {{(DIVIDEND_W+QUO_W-DEN_W){1'b0}}, tok_in.den} << SH;
        for (int l = 0; l < 3; l++) begin
            tok_next.quo[l*QUO_W +: QUO_W] = {tok_in.quo[l*QUO_W +: QUO_W-1], 1'b0};
            if ({{QUO_W{1'b0}}, tok_in.rem[l*DIVIDEND_W +: DIVIDEND_W]} >= dshift) begin
                tok_next.rem[l*DIVIDEND_W +: DIVIDEND_W] =
                    tok_in.rem[l*DIVIDEND_W +: DIVIDEND_W] - dshift[DIVIDEND_W-1:0];
                tok_next.quo[l*QUO_W +: QUO_W] = {tok_in.quo[l*QUO_W +: QUO_W-1], 1'b1};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else if (adv) begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule
`default_nettype wire

// ===== src/rotation_matrix_to_quaternion.sv =====
// Top level of the rotation-matrix to quaternion converter.
`default_nettype none
// Converts a 3x3 rotation matrix in signed Q1.14 to the quaternion w,x,y,z in
// the same format by Shepperd's method. One matrix is accepted every cycle
// unless the result side stalls; each passes the front stage, the 17-cell
// square-root chain, the division setup, the 17-cell division chain (one bit
// per cell) and the output register. A stall on the result side freezes the
// whole pipeline; the input is held off while a finished result waits to be taken.
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
(
    input  wire    aclk,
    input  wire    aresetn,
    input  wire    s_valid,
    output logic   s_ready,
    input  mat_t   s_data,
    output logic   m_valid,
    input  wire    m_ready,
    output quat_t  m_data
);

    // The pipeline advances unless the output holds a result not yet taken.
    logic adv;
    assign adv = !m_valid || m_ready;
    assign s_ready = adv;

    // Front stage: trace, branch choice, radicand and numerators.
    sqrt_tok_t front_reg, front_next;
    logic signed [17:0] tr, dd;
    logic signed [18:0] arg;

    always_comb begin
        front_next = '0;
        front_next.valid = s_valid;
        tr = 18'(s_data.m00) + 18'(s_data.m11) + 18'(s_data.m22);
        if (tr > 0) begin
            front_next.branch = BR_W;
            dd = tr;
            front_next.num_a = 18'(s_data.m21) - 18'(s_data.m12);
            front_next.num_b = 18'(s_data.m02) - 18'(s_data.m20);
            front_next.num_c = 18'(s_data.m10) - 18'(s_data.m01);
        end else if (s_data.m00 > s_data.m11 && s_data.m00 > s_data.m22) begin
            front_next.branch = BR_X;
            dd = 18'(s_data.m00) - 18'(s_data.m11) - 18'(s_data.m22);
            front_next.num_a = 18'(s_data.m21) - 18'(s_data.m12);
            front_next.num_b = 18'(s_data.m01) + 18'(s_data.m10);
            front_next.num_c = 18'(s_data.m02) + 18'(s_data.m20);
        end else if (s_data.m11 > s_data.m22) begin
            front_next.branch = BR_Y;
            dd = 18'(s_data.m11) - 18'(s_data.m00) - 18'(s_data.m22);
            front_next.num_a = 18'(s_data.m02) - 18'(s_data.m20);
            front_next.num_b = 18'(s_data.m01) + 18'(s_data.m10);
            front_next.num_c = 18'(s_data.m12) + 18'(s_data.m21);
        end else begin
            front_next.branch = BR_Z;
            dd = 18'(s_data.m22) - 18'(s_data.m00) - 18'(s_data.m11);
            front_next.num_a = 18'(s_data.m10) - 18'(s_data.m01);
            front_next.num_b = 18'(s_data.m02) + 18'(s_data.m20);
            front_next.num_c = 18'(s_data.m12) + 18'(s_data.m21);
        end
        arg = 19'(dd) + 19'sd16384;
        if (arg < 0) begin
            front_next.rem = '0;
        end else begin
            front_next.rem = RAD_W'({15'd0, arg}) << 14;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg.valid <= 1'b0;
        end else if (adv) begin
            front_reg <= front_next;
        end
    end

    // Square-root chain.
    sqrt_tok_t sq_chain [SQRT_STEPS+1];
    assign sq_chain[0] = front_reg;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        rmq_sqrt_cell #(.STEP(g)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .tok_in  (sq_chain[g]),
            .tok_out (sq_chain[g+1])
        );
    end

    // Division setup: the dividend is mag*16384 + S/2, so that dividing it by S
    // gives the quotient already rounded to nearest, halves away from zero.
    div_tok_t dsetup_reg, dsetup_next;
    sqrt_tok_t sq_end;
    logic [DEN_W-1:0] s_val;
    logic signed [NUM_W-1:0] nums [3];
    logic [MAG_W-1:0] mag;

    assign sq_end = sq_chain[SQRT_STEPS];

    always_comb begin
        dsetup_next = '0;
        dsetup_next.valid = sq_end.valid;
        dsetup_next.branch = sq_end.branch;
        s_val = {sq_end.root, 1'b0};
        dsetup_next.den = s_val;
        nums[0] = sq_end.num_a;
        nums[1] = sq_end.num_b;
        nums[2] = sq_end.num_c;
        mag = '0;
        for (int l = 0; l < 3; l++) begin
            mag = nums[l][NUM_W-1] ? MAG_W'(-nums[l]) : MAG_W'(nums[l]);
            dsetup_next.neg[l] = nums[l][NUM_W-1];
            dsetup_next.nz[l] = (nums[l] != 0);
            dsetup_next.rem[l*DIVIDEND_W +: DIVIDEND_W] =
                ({{(DIVIDEND_W-MAG_W){1'b0}}, mag} << 14)
                + {{(DIVIDEND_W-DEN_W){1'b0}}, 1'b0, s_val[DEN_W-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dsetup_reg.valid <= 1'b0;
        end else if (adv) begin
            dsetup_reg <= dsetup_next;
        end
    end

    // Division chain, one quotient bit per cell for each lane.
    div_tok_t dv_chain [QUO_W+1];
    assign dv_chain[0] = dsetup_reg;

    for (genvar g = 0; g < QUO_W; g++) begin : g_div
        rmq_div_cell #(.STEP(g)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .tok_in  (dv_chain[g]),
            .tok_out (dv_chain[g+1])
        );
    end

    // Final stage: clamp quotients, apply signs and place the components.
    div_tok_t dv_end;
    logic signed [15:0] comp [3];
    logic signed [15:0] big;
    logic [QUO_W-1:0] qv;
    logic signed [19:0] sv;
    quat_t out_next;
    quat_t out_reg;
    logic out_vld_reg;

    assign dv_end = dv_chain[QUO_W];

    always_comb begin
        qv = '0;
        sv = '0;
        for (int l = 0; l < 3; l++) begin
            qv = dv_end.quo[l*QUO_W +: QUO_W];
            if (dv_end.den == '0) begin
                comp[l] = !dv_end.nz[l] ? 16'sd0 : (dv_end.neg[l] ? 16'sh8000 : 16'sh7FFF);
            end else begin
                sv = dv_end.neg[l] ? -20'(qv) : 20'(qv);
                comp[l] = sat16(sv);
            end
        end
        big = sat16(20'((21'(dv_end.den) + 21'd2) >> 2));
        case (dv_end.branch)
            BR_W:    out_next = '{big, comp[0], comp[1], comp[2]};
            BR_X:    out_next = '{comp[0], big, comp[1], comp[2]};
            BR_Y:    out_next = '{comp[0], comp[1], big, comp[2]};
            default: out_next = '{comp[0], comp[1], comp[2], big};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= dv_end.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data = out_reg;

`ifndef NO_ASSERTIONS
    // An input taken must not be accepted while a result is stalled.
    a_no_accept_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted during output stall");

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_data) && m_valid)
        else $error("stalled result changed");

    // The large component of a zero divisor is zero.
    a_zero_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_end.valid && dv_end.den == '0) |-> big == 16'sd0)
        else $error("large component nonzero with zero divisor");
`endif

endmodule
`default_nettype wire
